### src/srrs_pkg.sv
// shared types, command encodings and constants of the steering roll-rate servo loop
package srrs_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 25;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W = PROD_W + 1;

  localparam logic [23:0] STEER_GAIN_RST = 24'd1966;
  localparam logic [23:0] DIFF_GAIN_RST = 24'd491520;
  localparam logic [23:0] ROLL_GAIN_RST = 24'd3408;
  localparam logic [16:0] DIFF_ALPHA_RST = 17'd2621;
  localparam logic [6:0] NEUTRAL_RST = 7'd0;
  localparam logic [15:0] PPD_RST = 16'd2844;
  localparam logic [14:0] STEER_LIMIT_RST = 15'd11520;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic signed [ACC_W-1:0] FILT_RND = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] CMD_RND = ACC_W'(8388608);
  localparam logic signed [ACC_W-1:0] DELTA_RND = ACC_W'(2048);
  localparam logic signed [33:0] TRUNC_BIAS = 34'sd65535;
  localparam logic signed [18:0] PULSE_CENTER = 19'sd1500;
  localparam logic signed [18:0] PULSE_MIN = 19'sd1010;
  localparam logic signed [18:0] PULSE_MAX = 19'sd1990;
  localparam logic [10:0] STAGE_LEN = 11'd1000;
  // floor(x * 4096 / 1000) == (x * DUTY_RECIP) >> DUTY_SHIFT for x below 1024
  localparam logic signed [MUL_B_W-1:0] DUTY_RECIP = MUL_B_W'(536871);
  localparam int DUTY_SHIFT = 17;

  typedef enum logic [2:0] {
    REG_STEER_GAIN,
    REG_DIFF_GAIN,
    REG_ROLL_GAIN,
    REG_DIFF_ALPHA,
    REG_NEUTRAL,
    REG_PPD,
    REG_STEER_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] steer_gain;
    logic [23:0] diff_gain_scaled;
    logic [23:0] roll_gain_per_tick;
    logic [16:0] diff_alpha;
    logic signed [6:0] neutral_offset;
    logic [15:0] pulse_per_degree;
    logic [14:0] steer_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FILT_OLD,
    MUL_FILT_NEW,
    MUL_DEV,
    MUL_FD,
    MUL_ROLL,
    MUL_PULSE,
    MUL_DUTY
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_FILT_LOAD,
    ACC_CMD_LOAD,
    ACC_DELTA_LOAD,
    ACC_ADD
  } acc_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PREP,
    OP_FD,
    OP_CRR,
    OP_ANGLE,
    OP_PULSE,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_sel_t acc;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic auto_mode;
    logic out_done;
  } dp_stat_t;

  localparam dp_cmd_t CMD_NONE = '{mul: MUL_NONE, acc: ACC_HOLD, op: OP_NONE};

endpackage

### src/srrs_cfg.sv
// apb register file holding the loop gains, trim and limits
module srrs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srrs_pkg::ADDR_W-1:0] paddr,
  input  logic [srrs_pkg::DATA_W-1:0] pwdata,
  output logic [srrs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output srrs_pkg::cfg_t              cfg
);
  import srrs_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steer_gain         <= STEER_GAIN_RST;
      cfg_r.diff_gain_scaled   <= DIFF_GAIN_RST;
      cfg_r.roll_gain_per_tick <= ROLL_GAIN_RST;
      cfg_r.diff_alpha         <= DIFF_ALPHA_RST;
      cfg_r.neutral_offset     <= NEUTRAL_RST;
      cfg_r.pulse_per_degree   <= PPD_RST;
      cfg_r.steer_limit        <= STEER_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_STEER_GAIN:  cfg_r.steer_gain         <= pwdata[23:0];
        REG_DIFF_GAIN:   cfg_r.diff_gain_scaled   <= pwdata[23:0];
        REG_ROLL_GAIN:   cfg_r.roll_gain_per_tick <= pwdata[23:0];
        REG_DIFF_ALPHA:  cfg_r.diff_alpha         <= pwdata[16:0];
        REG_NEUTRAL:     cfg_r.neutral_offset     <= pwdata[6:0];
        REG_PPD:         cfg_r.pulse_per_degree   <= pwdata[15:0];
        REG_STEER_LIMIT: cfg_r.steer_limit        <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_STEER_GAIN:  prdata = DATA_W'(cfg_r.steer_gain);
      REG_DIFF_GAIN:   prdata = DATA_W'(cfg_r.diff_gain_scaled);
      REG_ROLL_GAIN:   prdata = DATA_W'(cfg_r.roll_gain_per_tick);
      REG_DIFF_ALPHA:  prdata = DATA_W'(cfg_r.diff_alpha);
      REG_NEUTRAL:     prdata = DATA_W'(cfg_r.neutral_offset);
      REG_PPD:         prdata = DATA_W'(cfg_r.pulse_per_degree);
      REG_STEER_LIMIT: prdata = DATA_W'(cfg_r.steer_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

### src/srrs_ctrl.sv
// sequencer that steps one control tick through the shared multiplier datapath
module srrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srrs_pkg::dp_stat_t  stat,
  output srrs_pkg::dp_cmd_t   cmd
);
  import srrs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_OUT
  } state_t;

  state_t  state_r, state_nxt;
  dp_cmd_t cmd_r;
  logic    in_stall_r;

  function automatic dp_cmd_t cmd_of(state_t s);
    dp_cmd_t c;
    c = CMD_NONE;
    unique case (s)
      ST_IDLE: c = CMD_NONE;
      ST_PREP: c.op = OP_PREP;
      ST_F1:   c.mul = MUL_FILT_OLD;
      ST_F2: begin
        c.mul = MUL_FILT_NEW;
        c.acc = ACC_FILT_LOAD;
      end
      ST_F3:   c.acc = ACC_ADD;
      ST_F4:   c.op = OP_FD;
      ST_C1:   c.mul = MUL_DEV;
      ST_C2: begin
        c.mul = MUL_FD;
        c.acc = ACC_CMD_LOAD;
      end
      ST_C3:   c.acc = ACC_ADD;
      ST_C4:   c.op = OP_CRR;
      ST_R1:   c.mul = MUL_ROLL;
      ST_R2:   c.acc = ACC_DELTA_LOAD;
      ST_R3:   c.op = OP_ANGLE;
      ST_P1:   c.mul = MUL_PULSE;
      ST_P2:   c.op = OP_PULSE;
      ST_P3:   c.mul = MUL_DUTY;
      ST_OUT:  c.op = OP_OUT;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = stat.auto_mode ? ST_F1 : ST_P1;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_F3;
      ST_F3:   state_nxt = ST_F4;
      ST_F4:   state_nxt = ST_C1;
      ST_C1:   state_nxt = ST_C2;
      ST_C2:   state_nxt = ST_C3;
      ST_C3:   state_nxt = ST_C4;
      ST_C4:   state_nxt = ST_R1;
      ST_R1:   state_nxt = ST_R2;
      ST_R2:   state_nxt = ST_R3;
      ST_R3:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_OUT;
      ST_OUT:  if (stat.out_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cmd_r      <= CMD_NONE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cmd_r      <= cmd_of(state_nxt);
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign cmd      = cmd_r;
  assign in_stall = in_stall_r;

endmodule

### src/srrs_dp.sv
// datapath: loop state, shared multiplier, accumulator and output register
module srrs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  srrs_pkg::cfg_t      cfg,
  input  srrs_pkg::dp_cmd_t   cmd,
  output srrs_pkg::dp_stat_t  stat,
  input  logic                in_take,
  input  logic signed [15:0]  in_target_angle,
  input  logic signed [15:0]  in_roll_rate,
  input  logic signed [15:0]  in_sweep_offset,
  input  logic                in_closed_loop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [15:0]  out_steer_angle,
  output logic [10:0]         out_pulse_width,
  output logic [11:0]         out_duty_value
);
  import srrs_pkg::*;

  // loop state
  logic signed [15:0] steer_r, last_r;
  logic signed [23:0] fd_r;

  // captured tick
  logic signed [15:0] tgt_r, roll_r, sweep_r;
  logic               auto_r;

  // working registers
  logic signed [15:0]        dev_r;
  logic signed [16:0]        diff_r;
  logic signed [25:0]        crr_r;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [10:0]               pulse_r;

  // result register
  logic                      out_valid_r;
  logic signed [15:0]        out_steer_r;
  logic [10:0]               out_pulse_r;
  logic [11:0]               out_duty_r;

  logic [16:0]               alpha_c, one_m_alpha;
  logic signed [16:0]        trimmed;
  logic [9:0]                pulse_x;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   p_ext;

  logic signed [16:0]        dev_wide, man_wide;
  logic signed [15:0]        dev_c, man_c;
  logic signed [36:0]        fd_sh;
  logic signed [23:0]        fd_c;
  logic signed [40:0]        delta;
  logic signed [42:0]        ang_wide, lim_wide;
  logic signed [15:0]        ang_c;
  logic signed [32:0]        prod_pw;
  logic signed [33:0]        prod_adj;
  logic signed [18:0]        pw_wide;
  logic [10:0]               pw_c;
  logic                      out_free, out_done;

  assign alpha_c     = (cfg.diff_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.diff_alpha;
  assign one_m_alpha = ALPHA_ONE - alpha_c;
  assign trimmed     = {steer_r[15], steer_r}
                     + {{2{cfg.neutral_offset[6]}}, cfg.neutral_offset, 8'd0};
  assign pulse_x     = 10'(pulse_r - STAGE_LEN);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_FILT_OLD: begin
        mul_a = MUL_A_W'(fd_r);
        mul_b = $signed(MUL_B_W'(one_m_alpha));
      end
      MUL_FILT_NEW: begin
        mul_a = MUL_A_W'($signed({diff_r, 4'd0}));
        mul_b = $signed(MUL_B_W'(alpha_c));
      end
      MUL_DEV: begin
        mul_a = MUL_A_W'(dev_r);
        mul_b = $signed(MUL_B_W'(cfg.steer_gain));
      end
      MUL_FD: begin
        mul_a = MUL_A_W'(fd_r);
        mul_b = $signed(MUL_B_W'(cfg.diff_gain_scaled));
      end
      MUL_ROLL: begin
        mul_a = MUL_A_W'(crr_r);
        mul_b = $signed(MUL_B_W'(cfg.roll_gain_per_tick));
      end
      MUL_PULSE: begin
        mul_a = MUL_A_W'(trimmed);
        mul_b = $signed(MUL_B_W'(cfg.pulse_per_degree));
      end
      MUL_DUTY: begin
        mul_a = $signed(MUL_A_W'(pulse_x));
        mul_b = DUTY_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_ext = ACC_W'(p_r);

  always_comb begin
    acc_nxt = acc_r;
    unique case (cmd.acc)
      ACC_HOLD:       acc_nxt = acc_r;
      ACC_FILT_LOAD:  acc_nxt = p_ext + FILT_RND;
      ACC_CMD_LOAD:   acc_nxt = (p_ext <<< 4) + CMD_RND;
      ACC_DELTA_LOAD: acc_nxt = p_ext + DELTA_RND;
      ACC_ADD:        acc_nxt = acc_r + p_ext;
      default:        acc_nxt = acc_r;
    endcase
  end

  // saturating deviation and manual angle
  assign dev_wide = {tgt_r[15], tgt_r} - {steer_r[15], steer_r};
  assign dev_c    = (dev_wide[16] != dev_wide[15])
                  ? (dev_wide[16] ? 16'sh8000 : 16'sh7fff) : dev_wide[15:0];
  assign man_wide = {tgt_r[15], tgt_r} + {sweep_r[15], sweep_r};
  assign man_c    = (man_wide[16] != man_wide[15])
                  ? (man_wide[16] ? 16'sh8000 : 16'sh7fff) : man_wide[15:0];

  // filter output, floor then saturate to 24 bits
  assign fd_sh = acc_r[ACC_W-1:16];
  assign fd_c  = (fd_sh[36:23] == {14{fd_sh[23]}}) ? fd_sh[23:0]
               : (fd_sh[36] ? 24'sh800000 : 24'sh7fffff);

  // angle update with clamp to the limit
  assign delta    = acc_r[ACC_W-1:12];
  assign lim_wide = $signed({28'd0, cfg.steer_limit});
  assign ang_wide = 43'(steer_r) - 43'(delta) - 43'(sweep_r);
  always_comb begin
    priority if (ang_wide > lim_wide) begin
      ang_c = $signed({1'b0, cfg.steer_limit});
    end else if (ang_wide < -lim_wide) begin
      ang_c = 16'(-$signed({1'b0, cfg.steer_limit}));
    end else begin
      ang_c = ang_wide[15:0];
    end
  end

  // pulse: truncate toward zero, center, clamp
  assign prod_pw  = p_r[32:0];
  assign prod_adj = 34'(prod_pw) + (prod_pw[32] ? TRUNC_BIAS : 34'sd0);
  assign pw_wide  = 19'($signed(prod_adj[33:16])) + PULSE_CENTER;
  always_comb begin
    priority if (pw_wide < PULSE_MIN) begin
      pw_c = 11'(PULSE_MIN);
    end else if (pw_wide > PULSE_MAX) begin
      pw_c = 11'(PULSE_MAX);
    end else begin
      pw_c = pw_wide[10:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_done = (cmd.op == OP_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r     <= '0;
      last_r      <= '0;
      fd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_PREP) begin
        if (auto_r) begin
          last_r <= dev_c;
        end else begin
          steer_r <= man_c;
          last_r  <= '0;
          fd_r    <= '0;
        end
      end
      if (cmd.op == OP_FD) fd_r <= fd_c;
      if (cmd.op == OP_ANGLE) steer_r <= ang_c;
      if (out_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tgt_r   <= in_target_angle;
      roll_r  <= in_roll_rate;
      sweep_r <= in_sweep_offset;
      auto_r  <= in_closed_loop;
    end
    if (cmd.op == OP_PREP) begin
      dev_r  <= dev_c;
      diff_r <= {dev_c[15], dev_c} - {last_r[15], last_r};
    end
    if (cmd.mul != MUL_NONE) p_r <= mul_a * mul_b;
    acc_r <= acc_nxt;
    if (cmd.op == OP_CRR) crr_r <= $signed(acc_r[49:24]) - 26'(roll_r);
    if (cmd.op == OP_PULSE) pulse_r <= pw_c;
    if (out_done) begin
      out_steer_r <= steer_r;
      out_pulse_r <= pulse_r;
      out_duty_r  <= p_r[DUTY_SHIFT+11:DUTY_SHIFT];
    end
  end

  assign stat = '{auto_mode: auto_r, out_done: out_done};

  assign out_valid       = out_valid_r;
  assign out_steer_angle = out_steer_r;
  assign out_pulse_width = out_pulse_r;
  assign out_duty_value  = out_duty_r;

  a_angle_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_ANGLE |=> (17'(steer_r) <= $signed({2'b0, cfg.steer_limit}))
                        && (17'(steer_r) >= -$signed({2'b0, cfg.steer_limit})))
    else $error("steering angle outside limit after update");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_PULSE |=> (pulse_r >= 11'(PULSE_MIN)) && (pulse_r <= 11'(PULSE_MAX)))
    else $error("pulse width outside servo range");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_OUT))
    else $error("result raised without output step");

  a_manual_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PREP) && !auto_r |=> (fd_r == '0) && (last_r == '0))
    else $error("manual tick left filter state");

endmodule

### src/steer_roll_rate_servo_loop_top.sv
// Steering roll-rate servo loop top level. Each control tick is one input transfer and gives
// one result transfer. The tick runs through a sequencer that drives a single 27x25 multiplier
// with a registered product and an accumulator: an auto tick runs from acceptance to the
// result register through seven multiplies plus their accumulate, saturate and clamp steps,
// a manual tick through pulse scaling and duty conversion only. The input stalls until the
// tick reaches the result register, so a new tick is not accepted before the current one is
// through. A finished result sits in the output register until taken while the next tick is
// accepted; the last step waits there if the previous result is still held.
// Configuration must be written through the APB port only while the loop is idle; the block
// itself does not enforce it, and there is no clearing pass after reset.
module steer_roll_rate_servo_loop_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_target_angle,
  input  logic signed [15:0]          in_roll_rate,
  input  logic signed [15:0]          in_sweep_offset,
  input  logic                        in_closed_loop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_steer_angle,
  output logic [10:0]                 out_pulse_width,
  output logic [11:0]                 out_duty_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srrs_pkg::ADDR_W-1:0] paddr,
  input  logic [srrs_pkg::DATA_W-1:0] pwdata,
  output logic [srrs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import srrs_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_take;

  // input transfer
  assign in_take = in_valid && !in_stall;

  srrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srrs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .in_take         (in_take),
    .in_target_angle (in_target_angle),
    .in_roll_rate    (in_roll_rate),
    .in_sweep_offset (in_sweep_offset),
    .in_closed_loop  (in_closed_loop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_steer_angle (out_steer_angle),
    .out_pulse_width (out_pulse_width),
    .out_duty_value  (out_duty_value)
  );

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the steering roll-rate servo loop top level
`timescale 1ns / 1ps

module testbench;
  import srrs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam logic [2:0] REG_BEYOND = 3'd7;

  localparam longint ONE_Q16 = 65536;
  localparam longint ANGLE_MAX = 32767;
  localparam longint ANGLE_MIN = -32768;
  localparam longint FD_MAX = 8388607;
  localparam longint FD_MIN = -8388608;
  localparam longint PULSE_MID = 1500;
  localparam longint PULSE_LO = 1010;
  localparam longint PULSE_HI = 1990;
  localparam longint STAGE_US = 1000;
  localparam longint DUTY_STEPS = 4096;

  typedef enum {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_OFF} idle_mode_t;

  typedef struct packed {
    logic signed [15:0] target_angle;
    logic signed [15:0] roll_rate;
    logic signed [15:0] sweep_offset;
    logic               closed_loop;
  } servo_tick_t;

  typedef struct packed {
    logic signed [15:0] steer_angle;
    logic [10:0]        pulse_width;
    logic [11:0]        duty_value;
  } servo_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [15:0]   in_target_angle = '0;
  logic signed [15:0]   in_roll_rate = '0;
  logic signed [15:0]   in_sweep_offset = '0;
  logic                 in_closed_loop = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [15:0]   out_steer_angle;
  logic [10:0]          out_pulse_width;
  logic [11:0]          out_duty_value;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  steer_roll_rate_servo_loop_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_angle (in_target_angle),
    .in_roll_rate    (in_roll_rate),
    .in_sweep_offset (in_sweep_offset),
    .in_closed_loop  (in_closed_loop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_steer_angle (out_steer_angle),
    .out_pulse_width (out_pulse_width),
    .out_duty_value  (out_duty_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  servo_tick_t tick_q[$];
  servo_cmd_t  servo_cmd_q[$];
  servo_tick_t tick_on_bus = '0;
  idle_mode_t  idle_mode = IDLE_RX_HEAVY;

  cfg_t   loop_cfg = '{steer_gain: STEER_GAIN_RST, diff_gain_scaled: DIFF_GAIN_RST,
                       roll_gain_per_tick: ROLL_GAIN_RST, diff_alpha: DIFF_ALPHA_RST,
                       neutral_offset: NEUTRAL_RST, pulse_per_degree: PPD_RST,
                       steer_limit: STEER_LIMIT_RST};
  longint st_angle = 0;
  longint st_last_dev = 0;
  longint st_filt_diff = 0;

  int     ticks_sent = 0;
  int     cmds_checked = 0;
  int     settings_loaded = 0;
  int     mismatches = 0;
  int     cycles = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, servo_cmd_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // one control tick of the loop; advances the loop state
  function automatic servo_cmd_t servo_tick(servo_tick_t t);
    longint alpha, sg, dg, rg, ppd, lim, trim_deg;
    longint dev, dif, fd, cmd, delta, angle, trimmed, scaled, pulse, duty;
    servo_cmd_t r;
    sg = loop_cfg.steer_gain;
    dg = loop_cfg.diff_gain_scaled;
    rg = loop_cfg.roll_gain_per_tick;
    ppd = loop_cfg.pulse_per_degree;
    lim = loop_cfg.steer_limit;
    trim_deg = loop_cfg.neutral_offset;
    alpha = loop_cfg.diff_alpha;
    if (alpha > ONE_Q16) alpha = ONE_Q16;
    if (t.closed_loop) begin
      dev = clip(t.target_angle - st_angle, ANGLE_MIN, ANGLE_MAX);
      dif = dev - st_last_dev;
      fd = ((ONE_Q16 - alpha) * st_filt_diff + alpha * (dif * 16) + 32768) >>> 16;
      fd = clip(fd, FD_MIN, FD_MAX);
      cmd = (dev * sg * 16 + fd * dg + 8388608) >>> 24;
      delta = ((cmd - t.roll_rate) * rg + 2048) >>> 12;
      angle = clip(st_angle - delta - t.sweep_offset, -lim, lim);
      st_filt_diff = fd;
      st_last_dev = dev;
    end else begin
      angle = clip(longint'(t.target_angle) + longint'(t.sweep_offset), ANGLE_MIN, ANGLE_MAX);
      st_filt_diff = 0;
      st_last_dev = 0;
    end
    st_angle = angle;
    trimmed = angle + trim_deg * 256;
    scaled = trimmed * ppd;
    pulse = PULSE_MID + ((scaled < 0) ? -((-scaled) >>> 16) : (scaled >>> 16));
    pulse = clip(pulse, PULSE_LO, PULSE_HI);
    duty = (pulse - STAGE_US) * DUTY_STEPS / STAGE_US;
    r.steer_angle = angle[15:0];
    r.pulse_width = pulse[10:0];
    r.duty_value = duty[11:0];
    return r;
  endfunction

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_RX_HEAVY: return $urandom_range(99) < 18;
      IDLE_TX_HEAVY: return $urandom_range(99) < 51;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_gap();
    case (idle_mode)
      IDLE_RX_HEAVY: return $urandom_range(99) < 51;
      IDLE_TX_HEAVY: return $urandom_range(99) < 18;
      default:       return 1'b0;
    endcase
  endfunction

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        servo_cmd_q.push_back(servo_tick(tick_on_bus));
        ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && !sender_gap()) begin
          tick_on_bus = tick_q.pop_front();
          in_target_angle <= tick_on_bus.target_angle;
          in_roll_rate <= tick_on_bus.roll_rate;
          in_sweep_offset <= tick_on_bus.sweep_offset;
          in_closed_loop <= tick_on_bus.closed_loop;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    servo_cmd_t exp_cmd;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (servo_cmd_q.size() == 0) begin
          flag($sformatf("result with nothing due: angle %0d pulse %0d duty %0d",
                         out_steer_angle, out_pulse_width, out_duty_value));
        end else begin
          exp_cmd = servo_cmd_q.pop_front();
          cmds_checked++;
          if (out_steer_angle !== exp_cmd.steer_angle)
            flag($sformatf("result %0d steer_angle expected %0d got %0d", cmds_checked,
                           exp_cmd.steer_angle, out_steer_angle));
          if (out_pulse_width !== exp_cmd.pulse_width)
            flag($sformatf("result %0d pulse_width expected %0d got %0d", cmds_checked,
                           exp_cmd.pulse_width, out_pulse_width));
          if (out_duty_value !== exp_cmd.duty_value)
            flag($sformatf("result %0d duty_value expected %0d got %0d", cmds_checked,
                           exp_cmd.duty_value, out_duty_value));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_OFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= receiver_gap();
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_STEER_GAIN:  loop_cfg.steer_gain = val[23:0];
      REG_DIFF_GAIN:   loop_cfg.diff_gain_scaled = val[23:0];
      REG_ROLL_GAIN:   loop_cfg.roll_gain_per_tick = val[23:0];
      REG_DIFF_ALPHA:  loop_cfg.diff_alpha = val[16:0];
      REG_NEUTRAL:     loop_cfg.neutral_offset = val[6:0];
      REG_PPD:         loop_cfg.pulse_per_degree = val[15:0];
      REG_STEER_LIMIT: loop_cfg.steer_limit = val[14:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] sg, logic [31:0] dg, logic [31:0] rg,
                                logic [31:0] alpha, logic [31:0] trim, logic [31:0] ppd,
                                logic [31:0] lim);
    write_reg(REG_STEER_GAIN, sg);
    write_reg(REG_DIFF_GAIN, dg);
    write_reg(REG_ROLL_GAIN, rg);
    write_reg(REG_DIFF_ALPHA, alpha);
    write_reg(REG_NEUTRAL, trim);
    write_reg(REG_PPD, ppd);
    write_reg(REG_STEER_LIMIT, lim);
    settings_loaded++;
  endtask

  task automatic add_tick(bit auto_en, int target, int roll, int sweep);
    servo_tick_t t;
    t.target_angle = target[15:0];
    t.roll_rate = roll[15:0];
    t.sweep_offset = sweep[15:0];
    t.closed_loop = auto_en;
    tick_q.push_back(t);
  endtask

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // runs of ticks around a held target, with some noise ticks mixed in
  task automatic add_random_ticks(int count);
    int run_len, aim, target, roll, sweep;
    bit run_auto, auto_en;
    run_len = 0;
    aim = 0;
    run_auto = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (run_len == 0) begin
        run_len = $urandom_range(1, 24);
        run_auto = $urandom_range(99) < 85;
        aim = ($urandom_range(3) == 0) ? int'($urandom) : jitter(6000);
      end
      run_len--;
      if ($urandom_range(19) == 0) begin
        add_tick($urandom_range(1), $urandom, $urandom, $urandom);
      end else begin
        auto_en = ($urandom_range(19) == 0) ? !run_auto : run_auto;
        target = ($urandom_range(3) == 0) ? int'($urandom) : aim + jitter(64);
        roll = $urandom_range(1) ? int'($urandom) : jitter(400);
        case ($urandom_range(9))
          0:       sweep = $urandom;
          1, 2:    sweep = jitter(128);
          default: sweep = 0;
        endcase
        add_tick(auto_en, target, roll, sweep);
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || servo_cmd_q.size() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: saturation corners, deviation overflow, filter settling
    idle_mode = IDLE_RX_HEAVY;
    add_tick(1'b0, 0, 0, 0);
    add_tick(1'b0, 32767, 0, 32767);
    add_tick(1'b1, -32768, 0, 0);
    add_tick(1'b0, -32768, 0, -32768);
    add_tick(1'b1, 32767, 32767, 0);
    add_tick(1'b1, 32767, -32768, 32767);
    add_tick(1'b1, -32768, 32767, -32768);
    add_tick(1'b0, 16'h5555, 16'hAAAA, 16'h2AAA);
    repeat (6) add_tick(1'b1, 2560, 0, 0);
    add_tick(1'b1, 2560, 160, 0);
    add_tick(1'b1, -2560, -160, 256);
    add_tick(1'b0, 100, 32767, -200);
    add_tick(1'b1, 0, -1, -1);
    add_tick(1'b1, -1, 1, 1);
    add_tick(1'b0, 32767, -32768, 0);
    add_random_ticks(230);
    wait_quiet();

    apply_settings($urandom_range(8000), $urandom_range(1 << 20), $urandom_range(8000),
                   $urandom_range(65536), $urandom_range(90) - 45, $urandom_range(65535),
                   $urandom_range(23040));
    add_random_ticks(250);
    hold_req++;
    wait_quiet();

    idle_mode = IDLE_TX_HEAVY;
    apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 65536, 45, 65535, 23040);
    add_random_ticks(200);
    wait_quiet();

    apply_settings(0, 0, 0, 0, -45, 0, 0);
    add_random_ticks(150);
    wait_quiet();

    // alpha above one, trim and limit beyond their ranges, unmapped register
    idle_mode = IDLE_OFF;
    apply_settings($urandom_range(4000), $urandom_range(600000), $urandom_range(6000),
                   17'h1FFFF, 7'h40, $urandom_range(65535), 15'h7FFF);
    write_reg(REG_BEYOND, $urandom);
    add_random_ticks(250);
    wait_quiet();

    apply_settings($urandom, $urandom, $urandom, $urandom, 7'h3F, $urandom, $urandom);
    add_random_ticks(250);
    wait_quiet();

    apply_settings(STEER_GAIN_RST, DIFF_GAIN_RST, ROLL_GAIN_RST, $urandom_range(65536),
                   $urandom_range(90) - 45, PPD_RST, STEER_LIMIT_RST);
    add_random_ticks(200);
    hold_req++;
    wait_quiet();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (servo_cmd_q.size() != 0)
      flag($sformatf("%0d results never arrived", servo_cmd_q.size()));
    $display("%0d ticks through %0d register settings, %0d results checked",
             ticks_sent, settings_loaded, cmds_checked);
    $display("auto and manual ticks, saturation corners, two long output hold-offs, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
